// ===== design/cfvg_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table of the circle fan vertex generator.
package cfvg_pkg;

	localparam int MAX_SEGMENTS = 62;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 20;
	localparam int SEG_W        = 6;
	localparam int COORD_W      = 16;
	localparam int RADIUS_W     = 16;
	localparam int COLOR_W      = 32;
	localparam int GAIN_W       = 30;
	localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
	localparam int PROD_W       = RADIUS_W + GAIN_W;
	localparam int XY_W         = PROD_W + 3;
	localparam int Z_W          = 34;
	localparam int OFS_W        = 20;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int DIV_W        = ANGLE_BITS + 1;
	localparam int DCNT_W       = $clog2(DIV_W);
	localparam int FRAC_SHIFT   = 30;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CENTER,
		ST_INIT,
		ST_ROT,
		ST_MAP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_req;
		logic div_step;
		logic load_center;
		logic cordic_init;
		logic cordic_step;
		logic map;
		logic load_rim;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic rot_last;
		logic rim_last;
		logic out_free;
	} status_t;

	function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] k);
		logic [29:0] v;
		case (k)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10679838;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/cfvg_ctrl.sv =====
// Sequencer of the circle fan vertex generator: divider, center vertex, per-rim CORDIC passes.
module cfvg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cfvg_pkg::status_t status,
	output cfvg_pkg::cmd_t    cmd
);
	import cfvg_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_nx     = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_nx = ST_CENTER;
				end
			end
			ST_CENTER: begin
				if (status.out_free) begin
					cmd.load_center = 1'b1;
					state_nx        = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.cordic_init = 1'b1;
				state_nx        = ST_ROT;
			end
			ST_ROT: begin
				cmd.cordic_step = 1'b1;
				if (status.rot_last) begin
					state_nx = ST_MAP;
				end
			end
			ST_MAP: begin
				cmd.map  = 1'b1;
				state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_rim = 1'b1;
					state_nx     = status.rim_last ? ST_IDLE : ST_INIT;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/cfvg_datapath.sv =====
// Datapath: request hold, angle step divider, shared CORDIC rotator, rounding, saturation, output register.
module cfvg_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cfvg_pkg::cmd_t                      cmd,
	output cfvg_pkg::status_t                   status,
	input  logic signed [cfvg_pkg::COORD_W-1:0] center_x,
	input  logic signed [cfvg_pkg::COORD_W-1:0] center_y,
	input  logic [cfvg_pkg::RADIUS_W-1:0]       radius,
	input  logic [cfvg_pkg::COLOR_W-1:0]        fill_color,
	input  logic [cfvg_pkg::SEG_W-1:0]          segment_count,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [cfvg_pkg::COORD_W-1:0] vertex_x,
	output logic signed [cfvg_pkg::COORD_W-1:0] vertex_y,
	output logic [cfvg_pkg::COLOR_W-1:0]        vertex_color,
	output logic [cfvg_pkg::SEG_W-1:0]          vertex_number,
	output logic                                last_vertex
);
	import cfvg_pkg::*;

	localparam logic signed [XY_W-1:0] ROUND_HALF = XY_W'(64'd1 << (FRAC_SHIFT - 1));

	function automatic logic signed [COORD_W-1:0] sat16(input logic signed [OFS_W:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > (OFS_W + 1)'(32767)) begin
			r = 16'sh7FFF;
		end else if (v < -(OFS_W + 1)'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	logic signed [COORD_W-1:0]  cx_q, cy_q;
	logic [RADIUS_W-1:0]        rad_q;
	logic [COLOR_W-1:0]         color_q;
	logic [SEG_W-1:0]           n_q;
	logic [PROD_W-1:0]          prod_q;
	logic [SEG_W-1:0]           div_rem_q;
	logic [DIV_W-1:0]           div_quo_q;
	logic [DCNT_W-1:0]          div_cnt_q;
	logic [DIV_W-1:0]           acc_q;
	logic [SEG_W-1:0]           accr_q;
	logic [SEG_W-1:0]           rim_q;
	logic signed [XY_W-1:0]     x_q, y_q;
	logic signed [Z_W-1:0]      z_q;
	logic [STEP_W-1:0]          k_q;
	logic [1:0]                 quad_q;
	logic signed [OFS_W-1:0]    dx_q, dy_q;
	logic                       out_valid_q;
	logic signed [COORD_W-1:0]  vx_q, vy_q;
	logic [COLOR_W-1:0]         vcolor_q;
	logic [SEG_W-1:0]           vnum_q;
	logic                       vlast_q;

	logic [SEG_W-1:0]           n_eff;
	logic                       div_bit;
	logic [SEG_W:0]             rem_sh;
	logic                       rem_ge;
	logic [SEG_W:0]             rem_nx;
	logic [SEG_W:0]             r_sum;
	logic                       r_wrap;
	logic [SEG_W:0]             r_nx;
	logic signed [XY_W-1:0]     xs, ys;
	logic signed [Z_W-1:0]      atan_z;
	logic signed [XY_W-1:0]     cos_v, sin_v;
	logic signed [XY_W-1:0]     cos_r, sin_r;
	logic signed [OFS_W:0]      sum_x, sum_y;

	always_comb begin
		if (segment_count == '0) begin
			n_eff = SEG_W'(1);
		end else if (segment_count > SEG_W'(MAX_SEGMENTS)) begin
			n_eff = SEG_W'(MAX_SEGMENTS);
		end else begin
			n_eff = segment_count;
		end

		div_bit = (div_cnt_q == '0);
		rem_sh  = {div_rem_q, div_bit};
		rem_ge  = rem_sh >= {1'b0, n_q};
		rem_nx  = rem_ge ? rem_sh - {1'b0, n_q} : rem_sh;

		r_sum  = {1'b0, accr_q} + {1'b0, div_rem_q};
		r_wrap = r_sum >= {1'b0, n_q};
		r_nx   = r_wrap ? r_sum - {1'b0, n_q} : r_sum;

		xs     = x_q >>> k_q;
		ys     = y_q >>> k_q;
		atan_z = signed'(Z_W'(atan_turn(k_q)));

		case (quad_q)
			2'd0:    begin cos_v = x_q;  sin_v = y_q;  end
			2'd1:    begin cos_v = -y_q; sin_v = x_q;  end
			2'd2:    begin cos_v = -x_q; sin_v = -y_q; end
			default: begin cos_v = y_q;  sin_v = -x_q; end
		endcase
		cos_r = (cos_v + ROUND_HALF) >>> FRAC_SHIFT;
		sin_r = (sin_v + ROUND_HALF) >>> FRAC_SHIFT;

		sum_x = (OFS_W + 1)'(cx_q) + (OFS_W + 1)'(dx_q);
		sum_y = (OFS_W + 1)'(cy_q) + (OFS_W + 1)'(dy_q);

		status.div_last = div_cnt_q == DCNT_W'(DIV_W - 1);
		status.rot_last = k_q == STEP_W'(CORDIC_STEPS - 1);
		status.rim_last = rim_q == n_q;
		status.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(rad_q) * PROD_W'(GAIN_Q30);
		if (cmd.load_req) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			rad_q   <= radius;
			color_q <= fill_color;
		end
		if (cmd.div_step) begin
			div_quo_q <= {div_quo_q[DIV_W-2:0], rem_ge};
		end
		if (cmd.cordic_init) begin
			x_q    <= XY_W'(prod_q);
			y_q    <= '0;
			z_q    <= Z_W'({acc_q[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}});
			quad_q <= acc_q[ANGLE_BITS-1:ANGLE_BITS-2];
		end else if (cmd.cordic_step) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_z;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_z;
			end
		end
		if (cmd.map) begin
			dx_q <= cos_r[OFS_W-1:0];
			dy_q <= sin_r[OFS_W-1:0];
		end
		if (cmd.load_center) begin
			vx_q     <= cx_q;
			vy_q     <= cy_q;
			vcolor_q <= color_q;
			vnum_q   <= '0;
			vlast_q  <= 1'b0;
		end else if (cmd.load_rim) begin
			vx_q     <= sat16(sum_x);
			vy_q     <= sat16(sum_y);
			vcolor_q <= color_q;
			vnum_q   <= rim_q + SEG_W'(1);
			vlast_q  <= status.rim_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			div_rem_q   <= '0;
			div_cnt_q   <= '0;
			acc_q       <= '0;
			accr_q      <= '0;
			rim_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				n_q       <= n_eff;
				div_rem_q <= '0;
				div_cnt_q <= '0;
				acc_q     <= '0;
				accr_q    <= '0;
				rim_q     <= '0;
			end else if (cmd.div_step) begin
				div_rem_q <= rem_nx[SEG_W-1:0];
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
			end
			if (cmd.cordic_init) begin
				k_q <= '0;
			end else if (cmd.cordic_step) begin
				k_q <= k_q + STEP_W'(1);
			end
			if (cmd.load_rim) begin
				acc_q  <= acc_q + div_quo_q + DIV_W'(r_wrap);
				accr_q <= r_nx[SEG_W-1:0];
				rim_q  <= rim_q + SEG_W'(1);
			end
			if (cmd.load_center || cmd.load_rim) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign vertex_x      = vx_q;
	assign vertex_y      = vy_q;
	assign vertex_color  = vcolor_q;
	assign vertex_number = vnum_q;
	assign last_vertex   = vlast_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_center || cmd.load_rim) |-> (!out_valid_q || out_ready))
		else $error("vertex loaded over a pending one");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cordic_step |-> (k_q < STEP_W'(CORDIC_STEPS)))
		else $error("CORDIC step beyond table");

	a_rim_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cordic_init |-> (rim_q <= n_q))
		else $error("rim index past segment count");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q != '0) |-> ((accr_q < n_q) && (div_rem_q < n_q)))
		else $error("angle remainder out of range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_rim && status.rim_last) |=> (rim_q == n_q + SEG_W'(1)))
		else $error("fan did not end after last rim point");

endmodule

// ===== design/circle_fan_vertex_generator_top.sv =====
// Top level of the circle fan vertex generator: sequencer and datapath.
// One request (center, radius, color, segment count n, with 0 taken as 1 and 63 as 62)
// yields n+2 vertices: the center with number 0, then rim points 1..n+1 at angles
// floor(i*65536/n) turns/65536, the last one repeating the first and flagged last_vertex.
// A request runs a one-bit-per-cycle divider for the 17-bit angle step, then per rim point
// one 20-step pass of the shared CORDIC rotator, with a state each to load, round and
// saturate. One request is worked at a time; the next is taken as soon as the last vertex
// sits in the output register.
module circle_fan_vertex_generator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [cfvg_pkg::COORD_W-1:0] center_x,
	input  logic signed [cfvg_pkg::COORD_W-1:0] center_y,
	input  logic [cfvg_pkg::RADIUS_W-1:0]       radius,
	input  logic [cfvg_pkg::COLOR_W-1:0]        fill_color,
	input  logic [cfvg_pkg::SEG_W-1:0]          segment_count,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [cfvg_pkg::COORD_W-1:0] vertex_x,
	output logic signed [cfvg_pkg::COORD_W-1:0] vertex_y,
	output logic [cfvg_pkg::COLOR_W-1:0]        vertex_color,
	output logic [cfvg_pkg::SEG_W-1:0]          vertex_number,
	output logic                                last_vertex
);
	import cfvg_pkg::*;

	cmd_t    cmd;
	status_t status;

	cfvg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	cfvg_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.center_x      (center_x),
		.center_y      (center_y),
		.radius        (radius),
		.fill_color    (fill_color),
		.segment_count (segment_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.vertex_color  (vertex_color),
		.vertex_number (vertex_number),
		.last_vertex   (last_vertex)
	);

endmodule

// ===== tb/circle_fan_vertex_generator_top_tb.sv =====
// Self-checking testbench of the circle fan vertex generator: directed table, then random requests.
module circle_fan_vertex_generator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfvg_pkg::*;

	localparam int  N_DIRECTED  = 14;
	localparam int  N_RANDOM    = 296;
	localparam int  STALL_LIMIT = 20000;
	localparam int  HOLD_CYCLES = 3000;
	localparam int  DRAIN       = 2000;
	localparam int  SEG_MAX     = 62;
	localparam int  ROT_STEPS   = 20;
	localparam longint GAIN     = 64'sd652032874;

	localparam longint ATAN_TURNS [ROT_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087,
		667544, 333772, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304
	};

	typedef enum logic [0:0] {
		FAN_PREDICT,
		FAN_AT_CENTER
	} fan_kind_t;

	typedef struct packed {
		fan_kind_t                 kind;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [RADIUS_W-1:0]       rad;
		logic [COLOR_W-1:0]        color;
		logic [SEG_W-1:0]          seg;
	} fan_req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [COLOR_W-1:0]        color;
		logic [SEG_W-1:0]          num;
		logic                      last;
	} vertex_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic [RADIUS_W-1:0]       radius;
	logic [COLOR_W-1:0]        fill_color;
	logic [SEG_W-1:0]          segment_count;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic [COLOR_W-1:0]        vertex_color;
	logic [SEG_W-1:0]          vertex_number;
	logic                      last_vertex;

	fan_req_t offer;
	logic     rx_ready;
	logic     rx_hold;
	vertex_t  vertex_q [$];
	int       mismatches;
	int       idle_cycles;
	int       fans_taken;
	int       tx_calm;
	int       rx_calm;

	fan_req_t directed_reqs [N_DIRECTED] = '{
		'{FAN_AT_CENTER, 16'sh0123, -16'sd5, 16'd0, 32'h11223344, 6'd0},
		'{FAN_AT_CENTER, -16'sd32768, 16'sd32767, 16'd0, 32'hFFFFFFFF, 6'd5},
		'{FAN_AT_CENTER, 16'sd32767, -16'sd32768, 16'd0, 32'h00000000, 6'd63},
		'{FAN_PREDICT, 16'sd32767, 16'sd32767, 16'd65535, 32'hFF0000FF, 6'd4},
		'{FAN_PREDICT, -16'sd32768, -16'sd32768, 16'd65535, 32'h00FF00FF, 6'd4},
		'{FAN_PREDICT, 16'sd0, 16'sd0, 16'd65535, 32'hA5A5A5A5, 6'd62},
		'{FAN_PREDICT, 16'sd100, -16'sd100, 16'd1000, 32'h5A5A5A5A, 6'd63},
		'{FAN_PREDICT, 16'sd0, 16'sd0, 16'd16, 32'h00000001, 6'd1},
		'{FAN_PREDICT, 16'sd1600, 16'sd800, 16'd1600, 32'h80000000, 6'd0},
		'{FAN_PREDICT, -16'sd1, -16'sd1, 16'd1, 32'h7FFFFFFF, 6'd2},
		'{FAN_PREDICT, 16'sd0, 16'sd0, 16'd32768, 32'hDEADBEEF, 6'd3},
		'{FAN_PREDICT, 16'sd16384, -16'sd16384, 16'd40000, 32'h0F0F0F0F, 6'd8},
		'{FAN_PREDICT, 16'sh5555, 16'shAAAA, 16'h5555, 32'h55555555, 6'd42},
		'{FAN_PREDICT, 16'shAAAA, 16'sh5555, 16'hAAAA, 32'hAAAAAAAA, 6'd21}
	};

	circle_fan_vertex_generator_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.center_x      (center_x),
		.center_y      (center_y),
		.radius        (radius),
		.fill_color    (fill_color),
		.segment_count (segment_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.vertex_color  (vertex_color),
		.vertex_number (vertex_number),
		.last_vertex   (last_vertex)
	);

	assign center_x      = offer.cx;
	assign center_y      = offer.cy;
	assign radius        = offer.rad;
	assign fill_color    = offer.color;
	assign segment_count = offer.seg;
	assign out_ready     = rx_ready && !rx_hold;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void cordic_offset(input logic [31:0] angle, input logic [15:0] rad,
			output longint dx, output longint dy);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		longint c;
		longint s;
		x = $signed({48'd0, rad}) * GAIN;
		y = 0;
		z = $signed({34'd0, angle[29:0]});
		for (int k = 0; k < ROT_STEPS; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TURNS[k];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TURNS[k];
			end
		end
		case (angle[31:30])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		dx = (c + (64'sd1 <<< 29)) >>> 30;
		dy = (s + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[15:0];
	endfunction

	function automatic void expect_fan(input fan_req_t r);
		int          n;
		logic [31:0] step_num;
		logic [31:0] ang;
		longint      dx;
		longint      dy;
		vertex_t     v;
		n = (r.seg == 0) ? 1 : ((r.seg > SEG_MAX) ? SEG_MAX : int'(r.seg));
		v.x     = r.cx;
		v.y     = r.cy;
		v.color = r.color;
		v.num   = '0;
		v.last  = 1'b0;
		vertex_q.push_back(v);
		for (int i = 0; i <= n; i++) begin
			step_num = (i << 16) / n;
			ang = {step_num[15:0], 16'd0};
			if (r.kind == FAN_AT_CENTER) begin
				v.x = r.cx;
				v.y = r.cy;
			end else begin
				cordic_offset(ang, r.rad, dx, dy);
				v.x = clamp16(longint'(r.cx) + dx);
				v.y = clamp16(longint'(r.cy) + dy);
			end
			v.num  = SEG_W'(i + 1);
			v.last = (i == n);
			vertex_q.push_back(v);
		end
	endfunction

	function automatic int draw_gap(ref int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm_left = 30;
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	function automatic fan_req_t random_fan();
		fan_req_t r;
		r.kind = FAN_PREDICT;
		if ($urandom_range(0, 4) == 0) begin
			r.cx = $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 2000))
				: 16'sh8000 + 16'($urandom_range(0, 2000));
			r.cy = $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 2000))
				: 16'sh8000 + 16'($urandom_range(0, 2000));
		end else begin
			r.cx = 16'($urandom);
			r.cy = 16'($urandom);
		end
		case ($urandom_range(0, 9))
			0: r.rad = '0;
			1: r.rad = '1;
			2, 3, 4: r.rad = 16'($urandom_range(0, 255));
			default: r.rad = 16'($urandom);
		endcase
		r.color = $urandom;
		r.seg = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 8)) : 6'($urandom_range(0, 63));
		return r;
	endfunction

	task automatic send_fan(input fan_req_t r);
		int gap;
		gap = draw_gap(tx_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		offer    = r;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	always @(posedge clk) begin
		vertex_t e;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expect_fan(offer);
				fans_taken++;
			end
			if (out_valid && out_ready) begin
				if (vertex_q.size() == 0) begin
					mismatches++;
					$display("%0t: expected no vertex, got x=%0d y=%0d color=%h num=%0d last=%0b",
						$time, vertex_x, vertex_y, vertex_color, vertex_number,
						last_vertex);
				end else begin
					e = vertex_q.pop_front();
					if (vertex_x !== e.x || vertex_y !== e.y || vertex_color !== e.color
							|| vertex_number !== e.num || last_vertex !== e.last) begin
						mismatches++;
						$display("%0t: vertex mismatch expected x=%0d y=%0d color=%h num=%0d %s",
							$time, e.x, e.y, e.color, e.num,
							$sformatf("last=%0b, got x=%0d y=%0d color=%h num=%0d last=%0b",
								e.last, vertex_x, vertex_y, vertex_color,
								vertex_number, last_vertex));
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin : watchdog
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("circle_fan_vertex_generator_top regression: fail");
		$finish;
	end

	initial begin : receiver
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(rx_calm);
			if (gap > 0) begin
				@(negedge clk);
				rx_ready = 1'b0;
				repeat (gap) @(negedge clk);
				rx_ready = 1'b1;
			end else if (!rx_ready) begin
				@(negedge clk);
				rx_ready = 1'b1;
			end
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin : backpressure
		wait (fans_taken == 40);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		@(negedge clk);
		rx_hold = 1'b0;
	end

	initial begin : stimulus
		offer       = '0;
		in_valid    = 1'b0;
		rx_ready    = 1'b0;
		rx_hold     = 1'b0;
		mismatches  = 0;
		idle_cycles = 0;
		fans_taken  = 0;
		tx_calm     = 0;
		rx_calm     = 0;
		arst_n      = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int i = 0; i < N_DIRECTED; i++)
			send_fan(directed_reqs[i]);
		for (int i = 0; i < N_RANDOM; i++)
			send_fan(random_fan());
		@(negedge clk);
		in_valid = 1'b0;
		while (vertex_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("circle_fan_vertex_generator_top regression: pass");
		else
			$display("circle_fan_vertex_generator_top regression: fail");
		$finish;
	end

endmodule
